[sv/dns_name_decompressor_core_macros.svh]
// Assertion macros for the DNS name decompressor core.
// Needs nothing else; included by the top level only.
`ifndef DNS_NAME_DECOMPRESSOR_CORE_MACROS_SVH
`define DNS_NAME_DECOMPRESSOR_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define DNSD_ASSERT_IMPLY(lbl, clk, rst_n, lhs, rhs) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
        else $error("dnsd: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define DNSD_ASSERT_NEXT(lbl, clk, rst_n, lhs, rhs) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
        else $error("dnsd: next-cycle check failed");

`endif

[sv/dnsd_pkg.sv]
// Package for the DNS name decompressor: item structs, state and status codes,
// and byte constants. Depends on nothing.
`default_nettype none

package dnsd_pkg;

    // internal walk position: 14-bit pointer targets
    localparam int POS_W = 14;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic [1:0] PTR_TAG     = 2'b11;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [3:0] CHUNK_BYTES = 4'd8;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_PTR_TRUNC = 3'd1,
        ST_TOO_MANY  = 3'd2,
        ST_OVERRUN   = 3'd3,
        ST_TOO_LONG  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_PTR,
        S_CHAR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       op;
        logic [8:0] position;
        logic [7:0] byte_value;
        logic [9:0] msg_length;
    } t_in_item;

    typedef struct packed {
        logic [63:0] name_bytes;
        logic [3:0]  byte_count;
        logic        is_last;
        logic [2:0]  status;
        logic [9:0]  consumed;
    } t_out_item;

endpackage

`default_nettype wire

[sv/dns_name_decompressor_core.sv]
// DNS name decompressor core: message byte buffer and compressed-name walker.
// Depends on dnsd_pkg and dns_name_decompressor_core_macros.svh.
//
// Usage:
//   Input items are taken at a clock edge with start high and busy low.
//   A load item (op 0) writes byte_value at position and returns
//   nothing; busy stays low, so loads can stream every cycle.
//   A decode item (op 1) walks the buffer from position and raises busy until
//   its last result is out. The buffer read is registered, so from the accept
//   edge busy stays high through each length byte (terminator included), each
//   label character, both bytes of each pointer followed, and forming the final.
//   Results appear on o_item for one cycle with o_valid high: eight name
//   bytes per full chunk, then a final item with is_last, status and consumed.
//   The final result is shown in the cycle after the last busy cycle; busy is
//   already low then, so the next item may be accepted at the edge ending it.
//   The receiver cannot stall; every result must be taken as it appears.
//   If status is not ok, the chunks already sent for that decode are void.
//   Reset returns the walker to idle and clears the result strobe; buffer contents are
//   undefined until loaded, and there is no clearing pass.
`default_nettype none

`include "dns_name_decompressor_core_macros.svh"

module dns_name_decompressor_core #(
    parameter int MSG_BYTES    = 512,
    parameter int MAX_POINTERS = 10,
    parameter int MAX_NAME     = 255
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire dnsd_pkg::t_in_item  i_item,
    output logic                     busy,
    output logic                     o_valid,
    output dnsd_pkg::t_out_item      o_item
);

    localparam int AW    = $clog2(MSG_BYTES);
    localparam int LEN_W = $clog2(MSG_BYTES + 1);
    localparam int JW    = $clog2(MAX_POINTERS + 1);
    localparam int PW    = dnsd_pkg::POS_W;

    // message buffer
    logic [7:0] mem [MSG_BYTES];

    dnsd_pkg::t_state    r_state, n_state;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [8:0]          r_start, n_start;
    logic [PW-1:0]       r_pos, n_pos;
    logic [PW-1:0]       r_cur, n_cur;
    logic [7:0]          r_rem, n_rem;
    logic [5:0]          r_hi, n_hi;
    logic                r_jumped, n_jumped;
    logic [PW-1:0]       r_jump_end, n_jump_end;
    logic [JW-1:0]       r_jumps, n_jumps;
    logic [7:0]          r_n, n_n;
    logic [63:0]         r_chunk, n_chunk;
    logic [3:0]          r_cnt, n_cnt;
    dnsd_pkg::t_status   r_status, n_status;
    logic                r_valid, n_valid;
    dnsd_pkg::t_out_item r_out, n_out;
    logic [7:0]          r_rdata;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [PW-1:0] wr_pos;
    logic          go_next;
    logic [PW-1:0] next_p;
    logic          app_en;
    logic [7:0]    app_byte;
    logic [PW:0]   label_end;
    logic [PW-1:0] ptr_target;
    logic [PW-1:0] cons_full;
    logic [JW-1:0] jumps_inc;
    logic [3:0]    lane;

    assign wr_pos     = PW'(i_item.position);
    assign label_end  = {1'b0, r_pos} + (PW+1)'(1) + (PW+1)'(r_rdata);
    assign ptr_target = {r_hi, r_rdata};
    assign jumps_inc  = r_jumps + JW'(1);
    assign cons_full  = r_jumped ? (r_jump_end - PW'(r_start)) : (r_pos - PW'(r_start));

    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_start    = r_start;
        n_pos      = r_pos;
        n_cur      = r_cur;
        n_rem      = r_rem;
        n_hi       = r_hi;
        n_jumped   = r_jumped;
        n_jump_end = r_jump_end;
        n_jumps    = r_jumps;
        n_n        = r_n;
        n_chunk    = r_chunk;
        n_cnt      = r_cnt;
        n_status   = r_status;
        n_valid    = 1'b0;
        n_out      = r_out;
        rd_en      = 1'b0;
        rd_addr    = r_pos[AW-1:0];
        wr_en      = 1'b0;
        go_next    = 1'b0;
        next_p     = r_pos;
        app_en     = 1'b0;
        app_byte   = r_rdata;
        lane       = r_cnt;

        unique case (r_state)
            dnsd_pkg::S_IDLE: begin
                if (start) begin
                    if (i_item.op == dnsd_pkg::OP_LOAD) begin
                        wr_en = (wr_pos < PW'(MSG_BYTES));
                    end else begin
                        if (PW'(i_item.msg_length) > PW'(MSG_BYTES)) begin
                            n_len = LEN_W'(MSG_BYTES);
                        end else begin
                            n_len = LEN_W'(i_item.msg_length);
                        end
                        n_start  = i_item.position;
                        n_pos    = wr_pos;
                        n_jumped = 1'b0;
                        n_jumps  = '0;
                        n_n      = '0;
                        n_chunk  = '0;
                        n_cnt    = '0;
                        n_status = dnsd_pkg::ST_OK;
                        go_next  = 1'b1;
                        next_p   = wr_pos;
                    end
                end
            end
            dnsd_pkg::S_LEN: begin
                if (r_rdata[7:6] == dnsd_pkg::PTR_TAG) begin
                    if (r_pos + PW'(1) >= PW'(r_len)) begin
                        n_status = dnsd_pkg::ST_PTR_TRUNC;
                        n_state  = dnsd_pkg::S_DONE;
                    end else begin
                        n_hi    = r_rdata[5:0];
                        rd_en   = 1'b1;
                        rd_addr = AW'(r_pos + PW'(1));
                        n_state = dnsd_pkg::S_PTR;
                    end
                end else if (r_rdata == 8'd0) begin
                    n_pos   = r_pos + PW'(1);
                    n_state = dnsd_pkg::S_DONE;
                end else if (label_end > (PW+1)'(r_len)) begin
                    n_status = dnsd_pkg::ST_OVERRUN;
                    n_state  = dnsd_pkg::S_DONE;
                end else begin
                    // dot before every label but the first
                    app_en   = (r_n != 8'd0);
                    app_byte = dnsd_pkg::CH_DOT;
                    rd_en    = 1'b1;
                    rd_addr  = AW'(r_pos + PW'(1));
                    n_cur    = r_pos + PW'(1);
                    n_rem    = r_rdata;
                    n_pos    = label_end[PW-1:0];
                    n_state  = dnsd_pkg::S_CHAR;
                end
            end
            dnsd_pkg::S_PTR: begin
                if (!r_jumped) begin
                    n_jump_end = r_pos + PW'(2);
                end
                n_jumped = 1'b1;
                n_jumps  = jumps_inc;
                if (jumps_inc >= JW'(MAX_POINTERS)) begin
                    n_status = dnsd_pkg::ST_TOO_MANY;
                    n_state  = dnsd_pkg::S_DONE;
                end else begin
                    n_pos   = ptr_target;
                    go_next = 1'b1;
                    next_p  = ptr_target;
                end
            end
            dnsd_pkg::S_CHAR: begin
                app_en = 1'b1;
                if (r_rdata >= dnsd_pkg::CH_UPPER_A && r_rdata <= dnsd_pkg::CH_UPPER_Z) begin
                    app_byte = r_rdata + dnsd_pkg::CASE_OFFSET;
                end
                if (r_rem == 8'd1) begin
                    go_next = 1'b1;
                    next_p  = r_pos;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_cur + PW'(1));
                    n_cur   = r_cur + PW'(1);
                    n_rem   = r_rem - 8'd1;
                end
            end
            dnsd_pkg::S_DONE: begin
                n_valid          = 1'b1;
                n_out.is_last    = 1'b1;
                n_out.status     = r_status;
                if (r_status == dnsd_pkg::ST_OK) begin
                    n_out.name_bytes = r_chunk;
                    n_out.byte_count = r_cnt;
                    n_out.consumed   = cons_full[9:0];
                end else begin
                    n_out.name_bytes = '0;
                    n_out.byte_count = '0;
                    n_out.consumed   = '0;
                end
                n_state = dnsd_pkg::S_IDLE;
            end
            default: begin
                n_state = dnsd_pkg::S_IDLE;
            end
        endcase

        // start the next label or pointer, or stop at the message end
        if (go_next) begin
            if (next_p < PW'(n_len)) begin
                rd_en   = 1'b1;
                rd_addr = next_p[AW-1:0];
                n_state = dnsd_pkg::S_LEN;
            end else begin
                n_state = dnsd_pkg::S_DONE;
            end
        end

        // append one name byte, or stop with too-long status at the name limit; flush a full chunk first
        if (app_en) begin
            if (32'(r_n) >= MAX_NAME) begin
                n_status = dnsd_pkg::ST_TOO_LONG;
                n_state  = dnsd_pkg::S_DONE;
                rd_en    = 1'b0;
            end else begin
                n_n = r_n + 8'd1;
                if (r_cnt == dnsd_pkg::CHUNK_BYTES) begin
                    n_valid          = 1'b1;
                    n_out.name_bytes = r_chunk;
                    n_out.byte_count = dnsd_pkg::CHUNK_BYTES;
                    n_out.is_last    = 1'b0;
                    n_out.status     = dnsd_pkg::ST_OK;
                    n_out.consumed   = '0;
                    n_chunk          = '0;
                    lane             = 4'd0;
                end
                for (int i = 0; i < 8; i++) begin
                    if (lane == 4'(i)) begin
                        n_chunk[8*i +: 8] = app_byte;
                    end
                end
                n_cnt = lane + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_pos[AW-1:0]] <= i_item.byte_value;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dnsd_pkg::S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len      <= n_len;
        r_start    <= n_start;
        r_pos      <= n_pos;
        r_cur      <= n_cur;
        r_rem      <= n_rem;
        r_hi       <= n_hi;
        r_jumped   <= n_jumped;
        r_jump_end <= n_jump_end;
        r_jumps    <= n_jumps;
        r_n        <= n_n;
        r_chunk    <= n_chunk;
        r_cnt      <= n_cnt;
        r_status   <= n_status;
        r_out      <= n_out;
    end

    assign busy    = (r_state != dnsd_pkg::S_IDLE);
    assign o_valid = r_valid;
    assign o_item  = r_out;

    `DNSD_ASSERT_IMPLY(a_chunk_full, i_clk, i_rst_n, o_valid && !o_item.is_last,
        o_item.byte_count == dnsd_pkg::CHUNK_BYTES && o_item.status == dnsd_pkg::ST_OK)
    `DNSD_ASSERT_IMPLY(a_error_empty, i_clk, i_rst_n,
        o_valid && o_item.status != dnsd_pkg::ST_OK,
        o_item.is_last && o_item.byte_count == 4'd0 && o_item.consumed == 10'd0)
    `DNSD_ASSERT_NEXT(a_decode_busy, i_clk, i_rst_n,
        start && !busy && i_item.op == dnsd_pkg::OP_DECODE, busy)
    `DNSD_ASSERT_IMPLY(a_last_idle, i_clk, i_rst_n, o_valid && o_item.is_last,
        r_state == dnsd_pkg::S_IDLE)

endmodule

`default_nettype wire
